@@ hw/rtl/ipc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipc_pkg: shared types and constants of the implicit penalization cell
// Field widths of the datapath stages and the control group that travels
// with every word through the pipeline.
// ----------------------------------------------------------------------------
package ipc_pkg;

  localparam int VEL_W      = 32;  // Q16.16 velocity
  localparam int CHI_W      = 17;  // Q1.16 mask value
  localparam int MAG_W      = 33;  // magnitude of (target - free stream - velocity)
  localparam int K_W        = 49;  // lambda_dt * chi, units of 2^-32
  localparam int DEN_W      = 50;  // 2^32 + k
  localparam int NUM_W      = 82;  // magnitude * k
  localparam int Q_W        = 33;  // quotient bits
  localparam int IN_DATA_W  = 152;
  localparam int OUT_DATA_W = 72;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LAMBDA_DT,
    REG_FREE_STREAM_X,
    REG_FREE_STREAM_Y,
    REG_TARGET_MODE
  } cfg_reg_t;

  typedef struct packed {
    logic valid;
    logic zero;
    logic neg_x;
    logic neg_y;
  } ipc_ctrl_t;

endpackage

@@ hw/rtl/ipc_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipc_front: input stages of the implicit penalization cell
// Forms the strength k, the difference to the wanted velocity and its
// magnitude and sign over three register stages.
// ----------------------------------------------------------------------------
module ipc_front import ipc_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic             in_valid,
  input  logic [CHI_W-1:0] chi,
  input  logic [VEL_W-1:0] vel_x,
  input  logic [VEL_W-1:0] vel_y,
  input  logic [VEL_W-1:0] tgt_x,
  input  logic [VEL_W-1:0] tgt_y,
  input  logic             has_target,
  input  logic [VEL_W-1:0] lambda_dt,
  input  logic [VEL_W-1:0] fs_x,
  input  logic [VEL_W-1:0] fs_y,
  input  logic             target_mode,
  output logic [MAG_W-1:0] mag_x,
  output logic [MAG_W-1:0] mag_y,
  output logic [K_W-1:0]   k,
  output ipc_ctrl_t        ctrl
);

  logic [VEL_W-1:0] vel_in [2];
  logic [VEL_W-1:0] tgt_in [2];
  logic [VEL_W-1:0] fs_in  [2];

  ipc_ctrl_t        ctrl1, ctrl2, ctrl3;
  logic [K_W-1:0]   k1, k2, k3;
  logic [MAG_W-1:0] d1   [2];
  logic [VEL_W-1:0] u1   [2];
  logic [MAG_W:0]   diff2 [2];
  logic [MAG_W-1:0] mag3 [2];

  assign vel_in[0] = vel_x;
  assign vel_in[1] = vel_y;
  assign tgt_in[0] = tgt_x;
  assign tgt_in[1] = tgt_y;
  assign fs_in[0]  = fs_x;
  assign fs_in[1]  = fs_y;

  always_ff @(posedge clk) begin
    if (rst) begin
      ctrl1 <= '0;
      ctrl2 <= '0;
      ctrl3 <= '0;
    end else if (en) begin
      ctrl1 <= '{valid: in_valid, zero: target_mode & ~has_target, neg_x: 1'b0, neg_y: 1'b0};
      ctrl2 <= ctrl1;
      ctrl3 <= '{valid: ctrl2.valid, zero: ctrl2.zero,
                 neg_x: diff2[0][MAG_W], neg_y: diff2[1][MAG_W]};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      k1 <= lambda_dt * chi;
      k2 <= k1;
      k3 <= k2;
    end
  end

  for (genvar c = 0; c < 2; c++) begin : g_comp
    logic [VEL_W-1:0] tgt_eff;
    logic [MAG_W:0]   diff_neg;

    assign tgt_eff  = target_mode ? tgt_in[c] : '0;
    assign diff_neg = ~diff2[c] + 1'b1;

    always_ff @(posedge clk) begin
      if (en) begin
        d1[c]    <= {tgt_eff[VEL_W-1], tgt_eff} - {fs_in[c][VEL_W-1], fs_in[c]};
        u1[c]    <= vel_in[c];
        diff2[c] <= {d1[c][MAG_W-1], d1[c]} - {{2{u1[c][VEL_W-1]}}, u1[c]};
        mag3[c]  <= diff2[c][MAG_W] ? diff_neg[MAG_W-1:0] : diff2[c][MAG_W-1:0];
      end
    end
  end

  assign mag_x = mag3[0];
  assign mag_y = mag3[1];
  assign k     = k3;
  assign ctrl  = ctrl3;

endmodule

@@ hw/rtl/ipc_mul.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipc_mul: partial product multiplier of the implicit penalization cell
// Builds the numerator magnitude * k from 32-bit partial products over
// three stages and forms the divisor 2^32 + k.
// ----------------------------------------------------------------------------
module ipc_mul import ipc_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic [MAG_W-1:0] mag_x,
  input  logic [MAG_W-1:0] mag_y,
  input  logic [K_W-1:0]   k,
  input  ipc_ctrl_t        ctrl_in,
  output logic [NUM_W-1:0] num_x,
  output logic [NUM_W-1:0] num_y,
  output logic [DEN_W-1:0] den,
  output ipc_ctrl_t        ctrl_out
);

  localparam int LO_W = 32;

  logic [MAG_W-1:0] mag_in [2];
  logic [NUM_W-1:0] num3   [2];

  ipc_ctrl_t        ctrl1, ctrl2, ctrl3;
  logic [DEN_W-1:0] den1, den2, den3;

  assign mag_in[0] = mag_x;
  assign mag_in[1] = mag_y;

  always_ff @(posedge clk) begin
    if (rst) begin
      ctrl1 <= '0;
      ctrl2 <= '0;
      ctrl3 <= '0;
    end else if (en) begin
      ctrl1 <= ctrl_in;
      ctrl2 <= ctrl1;
      ctrl3 <= ctrl2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      den1 <= {1'b0, k} + (DEN_W'(1) << LO_W);
      den2 <= den1;
      den3 <= den2;
    end
  end

  for (genvar c = 0; c < 2; c++) begin : g_comp
    logic [2*LO_W-1:0] pp0_1, pp0_2;
    logic [K_W-1:0]    pp1_1, pp2_1;
    logic [DEN_W-1:0]  mid_2;

    always_ff @(posedge clk) begin
      if (en) begin
        pp0_1   <= mag_in[c][LO_W-1:0] * k[LO_W-1:0];
        pp1_1   <= mag_in[c][LO_W-1:0] * k[K_W-1:LO_W];
        pp2_1   <= mag_in[c][MAG_W-1] ? k : '0;
        pp0_2   <= pp0_1;
        mid_2   <= {1'b0, pp1_1} + {1'b0, pp2_1};
        num3[c] <= {{(DEN_W-LO_W)'(0), pp0_2[2*LO_W-1:LO_W]} + mid_2, pp0_2[LO_W-1:0]};
      end
    end
  end

  assign num_x    = num3[0];
  assign num_y    = num3[1];
  assign den      = den3;
  assign ctrl_out = ctrl3;

endmodule

@@ hw/rtl/ipc_div.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipc_div: pipelined restoring divider of the implicit penalization cell
// Divides both numerators by the shared divisor, one quotient bit per
// register stage, truncating toward zero.
// ----------------------------------------------------------------------------
module ipc_div import ipc_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic [NUM_W-1:0] num_x,
  input  logic [NUM_W-1:0] num_y,
  input  logic [DEN_W-1:0] den,
  input  ipc_ctrl_t        ctrl_in,
  output logic [Q_W-1:0]   q_x,
  output logic [Q_W-1:0]   q_y,
  output ipc_ctrl_t        ctrl_out
);

  logic [NUM_W-1:0] num_in [2];

  logic [DEN_W-1:0] rem_r [Q_W][2];
  logic [Q_W-1:0]   nq_r  [Q_W][2];
  logic [DEN_W-1:0] den_r [Q_W];
  ipc_ctrl_t        ctrl_r [Q_W];

  assign num_in[0] = num_x;
  assign num_in[1] = num_y;

  for (genvar s = 0; s < Q_W; s++) begin : g_step
    logic [DEN_W-1:0] den_p;
    ipc_ctrl_t        ctrl_p;

    if (s == 0) begin : g_first
      assign den_p  = den;
      assign ctrl_p = ctrl_in;
    end else begin : g_next
      assign den_p  = den_r[s-1];
      assign ctrl_p = ctrl_r[s-1];
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        ctrl_r[s] <= '0;
      end else if (en) begin
        ctrl_r[s] <= ctrl_p;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        den_r[s] <= den_p;
      end
    end

    for (genvar c = 0; c < 2; c++) begin : g_comp
      logic [DEN_W-1:0] rem_p;
      logic [Q_W-1:0]   nq_p;
      logic [DEN_W:0]   trial;
      logic [DEN_W:0]   rest;
      logic             take;

      if (s == 0) begin : g_first
        assign rem_p = {1'b0, num_in[c][NUM_W-1:Q_W]};
        assign nq_p  = num_in[c][Q_W-1:0];
      end else begin : g_next
        assign rem_p = rem_r[s-1][c];
        assign nq_p  = nq_r[s-1][c];
      end

      assign trial = {rem_p, nq_p[Q_W-1]};
      assign rest  = trial - {1'b0, den_p};
      assign take  = ~rest[DEN_W];

      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[s][c] <= take ? rest[DEN_W-1:0] : trial[DEN_W-1:0];
          nq_r[s][c]  <= {nq_p[Q_W-2:0], take};
        end
      end
    end
  end

  assign q_x      = nq_r[Q_W-1][0];
  assign q_y      = nq_r[Q_W-1][1];
  assign ctrl_out = ctrl_r[Q_W-1];

  // The partial remainder of a finished word is always below the divisor.
  a_rem_below_den: assert property (@(posedge clk) disable iff (rst)
    ctrl_r[Q_W-1].valid |-> (rem_r[Q_W-1][0] < den_r[Q_W-1]) &&
                            (rem_r[Q_W-1][1] < den_r[Q_W-1]))
    else $error("divider remainder not below divisor");

endmodule

@@ hw/rtl/ipc_out.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipc_out: result stage of the implicit penalization cell
// Applies the sign and clips to 32 bits or forces zero, then holds results
// in an output register with a skid entry behind it.
// ----------------------------------------------------------------------------
module ipc_out import ipc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic [Q_W-1:0]        q_x,
  input  logic [Q_W-1:0]        q_y,
  input  ipc_ctrl_t             ctrl,
  output logic                  advance,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata
);

  localparam logic [VEL_W-1:0] POS_MAX = {1'b0, {(VEL_W-1){1'b1}}};
  localparam logic [VEL_W-1:0] NEG_MIN = {1'b1, {(VEL_W-1){1'b0}}};

  logic                  skid_valid;
  logic [OUT_DATA_W-1:0] skid_data;
  logic [OUT_DATA_W-1:0] res_data;
  logic [VEL_W:0]        clip_x, clip_y;
  logic                  push, pop;

  function automatic logic [VEL_W:0] clip(input logic [Q_W-1:0] q, input logic neg);
    logic [Q_W-1:0] q_neg;
    logic [VEL_W:0] res;
    q_neg = ~q + 1'b1;
    if (neg) begin
      if (q > {1'b0, NEG_MIN}) begin
        res = {1'b1, NEG_MIN};
      end else begin
        res = {1'b0, q_neg[VEL_W-1:0]};
      end
    end else if (q > {1'b0, POS_MAX}) begin
      res = {1'b1, POS_MAX};
    end else begin
      res = {1'b0, q[VEL_W-1:0]};
    end
    return res;
  endfunction

  always_comb begin
    clip_x = clip(q_x, ctrl.neg_x);
    clip_y = clip(q_y, ctrl.neg_y);
    if (ctrl.zero) begin
      res_data = '0;
    end else begin
      res_data = {{(OUT_DATA_W-2*VEL_W-1){1'b0}}, clip_x[VEL_W] | clip_y[VEL_W],
                  clip_y[VEL_W-1:0], clip_x[VEL_W-1:0]};
    end
  end

  assign advance = ~skid_valid;
  assign push    = advance & ctrl.valid;
  assign pop     = m_tvalid & m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid   <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (pop) begin
        skid_valid <= 1'b0;
      end
    end else if (push) begin
      if (!m_tvalid || pop) begin
        m_tvalid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end else if (pop) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (pop) begin
        m_tdata <= skid_data;
      end
    end else if (push) begin
      if (!m_tvalid || pop) begin
        m_tdata <= res_data;
      end else begin
        skid_data <= res_data;
      end
    end
  end

  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> m_tvalid)
    else $error("skid entry held without an output word");

  a_skid_drains: assert property (@(posedge clk) disable iff (rst)
    (skid_valid && m_tready) |=> !skid_valid && m_tvalid)
    else $error("skid entry not moved to the output register");

  a_sat_clipped: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[2*VEL_W]) |->
      (m_tdata[VEL_W-1:0] == POS_MAX) || (m_tdata[VEL_W-1:0] == NEG_MIN) ||
      (m_tdata[2*VEL_W-1:VEL_W] == POS_MAX) || (m_tdata[2*VEL_W-1:VEL_W] == NEG_MIN))
    else $error("saturation flag without a clipped component");

endmodule

@@ hw/rtl/implicit_penalization_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// implicit_penalization_cell: implicit penalization correction per grid cell
// Computes (d - u) * k / (1 + k) for both velocity components in fixed point,
// truncated toward zero and clipped to 32 bits, with k = lambda_dt * chi.
// ----------------------------------------------------------------------------
// A word accepted on the slave side passes three input stages, three multiplier
// stages, 33 divider stages (one quotient bit each) and the output register
// before it is shown on the master side.
// Throughput: one word per cycle; a stall on the master side fills the skid
// entry and then holds the whole pipeline.
// Reset clears all valid bits and the configuration registers to zero.
module implicit_penalization_cell import ipc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  // mask_chi[16:0], velocity_x[48:17], velocity_y[80:49], target_x[112:81],
  // target_y[144:113], has_target[145], zero fill above
  input  logic [IN_DATA_W-1:0]  s_tdata,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // delta_x[31:0], delta_y[63:32], saturated[64], zero fill above
  output logic [OUT_DATA_W-1:0] m_tdata,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic [VEL_W-1:0] lambda_dt;
  logic [VEL_W-1:0] free_stream_x;
  logic [VEL_W-1:0] free_stream_y;
  logic             target_mode;

  logic             advance;
  logic [MAG_W-1:0] mag_x, mag_y;
  logic [K_W-1:0]   k;
  ipc_ctrl_t        front_ctrl, mul_ctrl, div_ctrl;
  logic [NUM_W-1:0] num_x, num_y;
  logic [DEN_W-1:0] den;
  logic [Q_W-1:0]   q_x, q_y;

  always_ff @(posedge clk) begin
    if (rst) begin
      lambda_dt     <= '0;
      free_stream_x <= '0;
      free_stream_y <= '0;
      target_mode   <= 1'b0;
    end else if (cfg_wr_en) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_LAMBDA_DT:     lambda_dt     <= cfg_data;
        REG_FREE_STREAM_X: free_stream_x <= cfg_data;
        REG_FREE_STREAM_Y: free_stream_y <= cfg_data;
        REG_TARGET_MODE:   target_mode   <= cfg_data[0];
      endcase
    end
  end

  assign s_tready = advance;

  ipc_front u_front (
    .clk         (clk),
    .rst         (rst),
    .en          (advance),
    .in_valid    (s_tvalid),
    .chi         (s_tdata[16:0]),
    .vel_x       (s_tdata[48:17]),
    .vel_y       (s_tdata[80:49]),
    .tgt_x       (s_tdata[112:81]),
    .tgt_y       (s_tdata[144:113]),
    .has_target  (s_tdata[145]),
    .lambda_dt   (lambda_dt),
    .fs_x        (free_stream_x),
    .fs_y        (free_stream_y),
    .target_mode (target_mode),
    .mag_x       (mag_x),
    .mag_y       (mag_y),
    .k           (k),
    .ctrl        (front_ctrl)
  );

  ipc_mul u_mul (
    .clk      (clk),
    .rst      (rst),
    .en       (advance),
    .mag_x    (mag_x),
    .mag_y    (mag_y),
    .k        (k),
    .ctrl_in  (front_ctrl),
    .num_x    (num_x),
    .num_y    (num_y),
    .den      (den),
    .ctrl_out (mul_ctrl)
  );

  ipc_div u_div (
    .clk      (clk),
    .rst      (rst),
    .en       (advance),
    .num_x    (num_x),
    .num_y    (num_y),
    .den      (den),
    .ctrl_in  (mul_ctrl),
    .q_x      (q_x),
    .q_y      (q_y),
    .ctrl_out (div_ctrl)
  );

  ipc_out u_out (
    .clk      (clk),
    .rst      (rst),
    .q_x      (q_x),
    .q_y      (q_y),
    .ctrl     (div_ctrl),
    .advance  (advance),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

endmodule

@@ dv/implicit_penalization_cell_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// implicit_penalization_cell_test: self-checking bench of the penalization cell
// Walks a short table of directed cells over several register settings, then
// streams random cells under random settings. Both stream sides idle in short
// bursts, and the result side holds off once for a long stretch. Every result
// word is checked against a bit-exact predictor, or a typed-in value.
// ----------------------------------------------------------------------------
module implicit_penalization_cell_test;
  import ipc_pkg::*;

  localparam int STALL_LIMIT = 2000;
  localparam int LONG_HOLD   = 300;
  localparam int DRAIN_WAIT  = 48;
  localparam int PHASE_ITEMS = 72;
  localparam int PHASES      = 6;

  typedef struct packed {
    logic        has_t;
    logic [31:0] ty;
    logic [31:0] tx;
    logic [31:0] vy;
    logic [31:0] vx;
    logic [16:0] chi;
  } cell_t;

  typedef struct packed {
    logic        sat;
    logic [31:0] dy;
    logic [31:0] dx;
  } correction_t;

  typedef struct packed {
    logic [31:0] lambda_dt;
    logic [31:0] fs_x;
    logic [31:0] fs_y;
    logic        target_mode;
  } setting_t;

  typedef struct packed {
    logic [2:0]  preset;
    logic        typed;
    correction_t want;
    cell_t       word;
  } vector_t;

  logic                  clk;
  logic                  rst       = 1'b1;
  logic [IN_DATA_W-1:0]  s_tdata   = '0;
  logic                  s_tvalid  = 1'b0;
  logic                  s_tready;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic                  m_tvalid;
  logic                  m_tready  = 1'b0;
  logic                  cfg_wr_en = 1'b0;
  cfg_reg_t              cfg_index = REG_LAMBDA_DT;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  logic [31:0]        lambda_dt_q   = '0;
  logic signed [31:0] fs_x_q        = '0;
  logic signed [31:0] fs_y_q        = '0;
  logic               target_mode_q = 1'b0;

  correction_t awaited[$];
  vector_t     directed[$];
  setting_t    presets[5];
  correction_t got;
  correction_t exp_word;
  int unsigned mismatches     = 0;
  int unsigned stalled_cycles = 0;
  bit          calm           = 1'b0;
  bit          hold_wanted    = 1'b0;

  implicit_penalization_cell DUT (
    .clk       (clk),
    .rst       (rst),
    .s_tdata   (s_tdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .m_tdata   (m_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [32:0] clip_component(longint diff, logic [48:0] k);
    logic [127:0] mag;
    logic [127:0] prod;
    logic [127:0] den;
    logic [127:0] q;
    logic [127:0] nq;
    mag = '0;
    mag[63:0] = (diff < 0) ? -diff : diff;
    prod = mag * k;
    den = (128'd1 << 32) + k;
    q = prod / den;
    nq = -q;
    if (diff < 0) begin
      if (q > 128'h8000_0000) return {1'b1, 32'h8000_0000};
      return {1'b0, nq[31:0]};
    end
    if (q > 128'h7FFF_FFFF) return {1'b1, 32'h7FFF_FFFF};
    return {1'b0, q[31:0]};
  endfunction

  function automatic correction_t penalize(cell_t c);
    correction_t r;
    logic [48:0] k;
    logic [32:0] cx;
    logic [32:0] cy;
    longint      tx;
    longint      ty;
    r = '0;
    tx = 0;
    ty = 0;
    if (target_mode_q) begin
      if (!c.has_t) return r;
      tx = $signed(c.tx);
      ty = $signed(c.ty);
    end
    k = lambda_dt_q * c.chi;
    cx = clip_component(tx - fs_x_q - $signed(c.vx), k);
    cy = clip_component(ty - fs_y_q - $signed(c.vy), k);
    r.dx = cx[31:0];
    r.dy = cy[31:0];
    r.sat = cx[32] | cy[32];
    return r;
  endfunction

  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 7))
      0: return 32'h0000_0000;
      1: return 32'hFFFF_FFFF;
      2: return 32'h7FFF_FFFF;
      3: return 32'h8000_0000;
      4, 5: return $urandom_range(0, 32'h0006_0000) - 32'h0003_0000;
      default: return $urandom;
    endcase
  endfunction

  task automatic add_row(int preset, logic [16:0] chi, logic [31:0] vx, logic [31:0] vy,
                         logic [31:0] tx, logic [31:0] ty, logic has_t, logic typed,
                         logic [31:0] dx = '0, logic [31:0] dy = '0, logic sat = 1'b0);
    vector_t v;
    v.preset = 3'(preset);
    v.typed = typed;
    v.want = {sat, dy, dx};
    v.word = {has_t, ty, tx, vy, vx, chi};
    directed.push_back(v);
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [31:0] val);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
  endtask

  task automatic apply_setting(setting_t s);
    s_tvalid <= 1'b0;
    while (awaited.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
    write_reg(REG_LAMBDA_DT, s.lambda_dt);
    write_reg(REG_FREE_STREAM_X, s.fs_x);
    write_reg(REG_FREE_STREAM_Y, s.fs_y);
    write_reg(REG_TARGET_MODE, {31'd0, s.target_mode});
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    lambda_dt_q = s.lambda_dt;
    fs_x_q = s.fs_x;
    fs_y_q = s.fs_y;
    target_mode_q = s.target_mode;
  endtask

  task automatic send_cell(cell_t c, logic typed, correction_t want);
    bit took;
    if (!calm && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    s_tdata  <= IN_DATA_W'(c);
    s_tvalid <= 1'b1;
    do begin
      @(negedge clk);
      took = s_tready;
      @(posedge clk);
    end while (!took);
    awaited.push_back(typed ? want : penalize(c));
  endtask

  initial begin
    wait (!rst);
    @(posedge clk);
    forever begin
      if (hold_wanted) begin
        hold_wanted = 1'b0;
        m_tready <= 1'b0;
        for (int h = 0; h < LONG_HOLD; h++) @(posedge clk);
      end else if (!calm && $urandom_range(0, 2) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 5)) @(posedge clk);
      end
      m_tready <= 1'b1;
      repeat ($urandom_range(1, 20)) @(posedge clk);
    end
  end

  always @(negedge clk) begin
    if (m_tvalid && m_tready) begin
      got = m_tdata[64:0];
      if (awaited.size() == 0) begin
        $error("result word with nothing pending: delta_x %0d delta_y %0d saturated %0b",
               $signed(got.dx), $signed(got.dy), got.sat);
        mismatches++;
      end else begin
        exp_word = awaited.pop_front();
        if (got.dx !== exp_word.dx) begin
          $error("delta_x expected %0d actual %0d", $signed(exp_word.dx), $signed(got.dx));
          mismatches++;
        end
        if (got.dy !== exp_word.dy) begin
          $error("delta_y expected %0d actual %0d", $signed(exp_word.dy), $signed(got.dy));
          mismatches++;
        end
        if (got.sat !== exp_word.sat) begin
          $error("saturated expected %0b actual %0b", exp_word.sat, got.sat);
          mismatches++;
        end
      end
    end
  end

  always @(negedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) stalled_cycles = 0;
    else stalled_cycles++;
    if (stalled_cycles >= STALL_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    cell_t      c;
    setting_t   s;
    logic [2:0] cur;

    presets[0] = {32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b0};
    presets[1] = {32'h0001_0000, 32'h0000_0000, 32'h0000_0000, 1'b0};
    presets[2] = {32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0};
    presets[3] = {32'h0002_8000, 32'h0001_0000, 32'hFFFF_0000, 1'b1};
    presets[4] = {32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0000, 1'b1};

    // Registers still at reset: zero strength everywhere.
    add_row(0, 17'h1FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 1, 1);
    add_row(0, 17'h00000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 0, 1);
    add_row(0, 17'h10000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h1234_5678, 32'h8765_4321, 1, 1);
    // Unit strength: k = chi, so chi of one halves the velocity.
    add_row(1, 17'h10000, 32'h0002_0000, 32'hFFFE_0000, 32'h0, 32'h0, 0, 1,
            32'hFFFF_0000, 32'h0001_0000, 1'b0);
    add_row(1, 17'h00000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'h0, 0, 1);
    add_row(1, 17'h10000, 32'h0000_0001, 32'hFFFF_FFFF, 32'h0, 32'h0, 1, 1);
    add_row(1, 17'h1FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'h0, 0, 0);
    add_row(1, 17'h00001, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h0, 1, 0);
    add_row(1, 17'h08000, 32'h0001_2345, 32'hFFFE_DCBA, 32'hA5A5_A5A5, 32'h5A5A_5A5A, 1, 0);
    // Largest strength with extreme free stream.
    add_row(2, 17'h10000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'h0, 0, 1,
            32'h8000_0000, 32'h7FFF_FFFF, 1'b1);
    add_row(2, 17'h10000, 32'h8000_0001, 32'h7FFF_FFFF, 32'h0, 32'h0, 1, 1);
    add_row(2, 17'h00001, 32'h0000_0000, 32'h0000_0000, 32'h0, 32'h0, 0, 0);
    add_row(2, 17'h1FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'h0, 1, 0);
    // Target mode: cells without a target give no correction.
    add_row(3, 17'h1FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 0, 1);
    add_row(3, 17'h10000, 32'h1234_5678, 32'hFEDC_BA98, 32'h0003_0000, 32'hFFFD_0000, 0, 1);
    add_row(3, 17'h10000, 32'h0000_0000, 32'h0000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 1, 0);
    add_row(3, 17'h09C40, 32'h0000_8000, 32'hFFFF_8000, 32'h0003_0000, 32'hFFFD_0000, 1, 0);
    add_row(3, 17'h00000, 32'h0000_8000, 32'hFFFF_8000, 32'h7FFF_FFFF, 32'h8000_0000, 1, 1);
    add_row(4, 17'h10000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 1, 1,
            32'h7FFF_FFFF, 32'h8000_0000, 1'b1);
    add_row(4, 17'h10000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 0, 1);
    add_row(4, 17'h10000, 32'h0001_0000, 32'h0000_0000, 32'h0000_0000, 32'h0001_0000, 1, 0);

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    cur = 3'd0;
    foreach (directed[i]) begin
      if (directed[i].preset != cur) begin
        cur = directed[i].preset;
        apply_setting(presets[cur]);
      end
      send_cell(directed[i].word, directed[i].typed, directed[i].want);
    end

    for (int p = 0; p < PHASES; p++) begin
      case ($urandom_range(0, 5))
        0: s.lambda_dt = 32'h0000_0000;
        1: s.lambda_dt = 32'hFFFF_FFFF;
        2: s.lambda_dt = $urandom;
        default: s.lambda_dt = $urandom_range(32'h0000_1000, 32'h0040_0000);
      endcase
      s.fs_x = pick_word();
      s.fs_y = pick_word();
      s.target_mode = p[0];
      apply_setting(s);
      calm = (p == PHASES - 1);
      if (p == 1) hold_wanted = 1'b1;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        case ($urandom_range(0, 9))
          0: c.chi = 17'h00000;
          1: c.chi = 17'h10000;
          2: c.chi = 17'($urandom_range(17'h10001, 17'h1FFFF));
          default: c.chi = 17'($urandom_range(0, 17'h10000));
        endcase
        c.vx = pick_word();
        c.vy = pick_word();
        c.tx = pick_word();
        c.ty = pick_word();
        c.has_t = ($urandom_range(0, 3) != 0);
        send_cell(c, 1'b0, '0);
      end
    end

    s_tvalid <= 1'b0;
    while (awaited.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
